// File: hw/rtl/bps_pkg.sv
// Shared types, operation codes and constants of the beep pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEEP  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 8'd3;

    localparam logic [15:0] DEFAULT_BEEP_HZ       = 16'd1000;
    localparam logic [15:0] DEFAULT_BEEP_MS       = 16'd200;
    localparam logic [15:0] RESET_PATTERN_HZ      = 16'd2000;
    localparam logic [15:0] RESET_PATTERN_ON      = 16'd200;
    localparam logic [15:0] RESET_PATTERN_OFF     = 16'd200;
    localparam logic [7:0]  RESET_PATTERN_REPEATS = 8'd5;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [7:0]  repeat_count;
    } bps_cfg_t;

    typedef struct packed {
        logic        tone_active;
        logic [15:0] tone_hz;
        logic        tone_from_pattern;
        logic [15:0] tone_time_left;
        logic        sequence_running;
        logic        in_on_phase;
        logic [15:0] off_phase_elapsed;
        logic [7:0]  repeats_done;
    } bps_state_t;

    typedef struct packed {
        logic        tone_enable;
        logic [15:0] tone_frequency;
        logic        pattern_busy;
    } bps_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bps_step.sv
// Next-state logic of the sequencer for one operation.
`timescale 1ns / 1ps
`default_nettype none

module bps_step
    import bps_pkg::*;
(
    input  wire bps_state_t  state_cur,
    input  wire bps_cfg_t    cfg,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] beep_freq,
    input  wire logic [15:0] beep_length,
    output bps_state_t       state_nxt
);

    function automatic bps_state_t start_tone(bps_state_t st, logic [15:0] hz,
                                               logic [15:0] ms, logic from_pattern);
        bps_state_t r;
        r                   = st;
        r.tone_active       = 1'b1;
        r.tone_hz           = (hz == 16'd0) ? DEFAULT_BEEP_HZ : hz;
        r.tone_time_left    = (ms == 16'd0) ? DEFAULT_BEEP_MS : ms;
        r.tone_from_pattern = from_pattern;
        return r;
    endfunction

    function automatic bps_state_t count_down(bps_state_t st);
        bps_state_t r;
        r = st;
        if (st.tone_active)
        begin
            if (st.tone_time_left <= 16'd1)
            begin
                r.tone_time_left = 16'd0;
                r.tone_active    = 1'b0;
            end
            else
            begin
                r.tone_time_left = st.tone_time_left - 16'd1;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        bps_state_t  s;
        logic [15:0] elapsed_inc;
        logic [7:0]  repeats_inc;
        s           = state_cur;
        elapsed_inc = '0;
        repeats_inc = '0;
        unique case (op)
            OP_TICK:
            begin
                if (!s.sequence_running)
                begin
                    // a leftover pattern tone holds until stopped
                    if (!s.tone_from_pattern)
                    begin
                        s = count_down(s);
                    end
                end
                else
                begin
                    s = count_down(s);
                    if (s.in_on_phase)
                    begin
                        if (!s.tone_active)
                        begin
                            s.in_on_phase       = 1'b0;
                            s.off_phase_elapsed = 16'd0;
                        end
                    end
                    else
                    begin
                        elapsed_inc = (s.off_phase_elapsed == 16'hFFFF) ?
                                      s.off_phase_elapsed : s.off_phase_elapsed + 16'd1;
                        s.off_phase_elapsed = elapsed_inc;
                        if (elapsed_inc >= cfg.off_time)
                        begin
                            repeats_inc = (s.repeats_done == 8'hFF) ?
                                          s.repeats_done : s.repeats_done + 8'd1;
                            s.repeats_done = repeats_inc;
                            if (repeats_inc >= cfg.repeat_count)
                            begin
                                s.sequence_running = 1'b0;
                            end
                            else
                            begin
                                s.in_on_phase       = 1'b1;
                                s.off_phase_elapsed = 16'd0;
                                s = start_tone(s, cfg.tone_freq, cfg.on_time, 1'b1);
                            end
                        end
                    end
                end
            end
            OP_BEEP:
            begin
                s = start_tone(s, beep_freq, beep_length, 1'b0);
            end
            OP_START:
            begin
                s.sequence_running  = 1'b1;
                s.repeats_done      = 8'd0;
                s.in_on_phase       = 1'b1;
                s.off_phase_elapsed = 16'd0;
                s = start_tone(s, cfg.tone_freq, cfg.on_time, 1'b1);
            end
            OP_STOP:
            begin
                s.tone_active = 1'b0;
            end
            default:
            begin
                s = state_cur;
            end
        endcase
        state_nxt = s;
    end

endmodule

`default_nettype wire

// File: hw/rtl/beep_pattern_sequencer_unit.sv
// Top level of the beep pattern sequencer: config registers, state and result buffer.
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   tick of one millisecond, single beep (beep_freq, beep_length), start the
//   alarm pattern, or stop the tone. Every transfer yields exactly one result
//   on the output channel (out_valid / out_stall): tone_enable,
//   tone_frequency and pattern_busy as they stand after that operation.
//   The result of an operation is registered in the output register, or in
//   the skid register while the receiver stalls.
//   One operation is taken per cycle while in_stall is low; the state update is a single
//   counter/compare pass between the state register and the result register.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more; in_stall rises only while the skid is full.
//   Reset clears the sequencer state and both buffers, and loads the pattern
//   registers with 2000 Hz, 200 ms on, 200 ms off, 5 repeats.
//   Write the pattern registers through cfg_we / cfg_index / cfg_wdata only
//   while no result is outstanding; unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module beep_pattern_sequencer_unit
    import bps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            op,
    input  wire logic [15:0]           beep_freq,
    input  wire logic [15:0]           beep_length,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       tone_enable,
    output logic [15:0]                tone_frequency,
    output logic                       pattern_busy
);

    bps_cfg_t    cfg_reg;
    bps_state_t  state_reg;
    bps_state_t  state_next;
    bps_result_t result_next;
    bps_result_t out_data_reg;
    bps_result_t skid_data_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_xfer;
    logic        out_free;

    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_freq    <= RESET_PATTERN_HZ;
            cfg_reg.on_time      <= RESET_PATTERN_ON;
            cfg_reg.off_time     <= RESET_PATTERN_OFF;
            cfg_reg.repeat_count <= RESET_PATTERN_REPEATS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TONE_FREQ:    cfg_reg.tone_freq    <= cfg_wdata;
                CFG_ON_TIME:      cfg_reg.on_time      <= cfg_wdata;
                CFG_OFF_TIME:     cfg_reg.off_time     <= cfg_wdata;
                CFG_REPEAT_COUNT: cfg_reg.repeat_count <= cfg_wdata[7:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bps_step u_step (
        .state_cur   (state_reg),
        .cfg         (cfg_reg),
        .op          (op),
        .beep_freq   (beep_freq),
        .beep_length (beep_length),
        .state_nxt   (state_next)
    );

    assign result_next.tone_enable    = state_next.tone_active;
    assign result_next.tone_frequency = state_next.tone_hz;
    assign result_next.pattern_busy   = state_next.sequence_running;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || in_xfer;
                skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload only; older skid entry drains ahead of a new transfer
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_xfer)
            begin
                out_data_reg <= result_next;
            end
        end
        else if (in_xfer)
        begin
            skid_data_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tone_enable    = out_data_reg.tone_enable;
    assign tone_frequency = out_data_reg.tone_frequency;
    assign pattern_busy   = out_data_reg.pattern_busy;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_on_phase_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_on_phase |-> state_reg.sequence_running)
        else $error("on phase flagged with no pattern running");

    a_tone_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tone_active |-> (state_reg.tone_time_left != 16'd0))
        else $error("active tone with no time left");

    a_stop_silences: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (op == OP_STOP)) |=> !state_reg.tone_active)
        else $error("tone still active after stop");

endmodule

`default_nettype wire
